// ----- src/slsfr_pkg.sv -----
// ============================================================================
// slsfr_pkg - shared types and constants of the frame receiver
// Payload structs, result kinds, opcodes, register map and sizing.
// ============================================================================
package slsfr_pkg;

    localparam int MAX_FRAME = 64;
    localparam int ADDR_W    = $clog2(MAX_FRAME);
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int LEN_W     = 9;

    localparam logic [7:0] SYNC_BYTE      = 8'h55;
    localparam logic [7:0] FRAME_OVERHEAD = 8'd4;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_CHECKSUM = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;
    localparam logic [1:0] KIND_TIMEOUT  = 2'd3;

    localparam logic REG_TIMEOUT = 1'b0;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } evt_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic       last;
    } res_t;

endpackage

// ----- src/sync_length_sum_frame_receiver.sv -----
// ============================================================================
// sync_length_sum_frame_receiver - length-byte, sum-8 serial frame deframer
// Timing: an error result appears on the output in the cycle after its input
// transfer; a good frame goes from its checksum byte through the read state,
// the store's read register and the output register, one byte per cycle while
// the output is not stalled. Throughput: one input transfer per cycle while
// filling with output free; input is held off until a good frame is read out.
// Reset: no frame open, idle count zero, timeout register 100.
// ============================================================================
module sync_length_sum_frame_receiver
    import slsfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        evt_valid,
    output logic        evt_stall,
    input  evt_t        evt,
    output logic        res_valid,
    input  logic        res_stall,
    output res_t        res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       len_reg, len_next;
    logic [15:0]      idle_reg, idle_next;
    logic [15:0]      timeout_reg;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] pend_idx_reg, pend_idx_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg, out_next;

    logic             evt_fire;
    logic             out_free;
    logic             err_fire;
    logic [1:0]       err_kind;
    logic             mem_we;
    logic             mem_re;
    logic [7:0]       mem_rdata;
    logic [CNT_W-1:0] count_inc;
    logic [15:0]      idle_inc;
    logic [LEN_W-1:0] need;

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_reg} : 32'd0;
    assign out_free  = !out_valid_reg || !res_stall;
    assign evt_stall = (state_reg != ST_IDLE) || !out_free;
    assign evt_fire  = evt_valid && !evt_stall;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign count_inc = count_reg + CNT_W'(1);
    assign idle_inc  = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign need      = LEN_W'(len_reg) + LEN_W'(FRAME_OVERHEAD);
    assign mem_re    = (state_reg == ST_READ) && (rd_ptr_reg < n_reg)
                       && (!pend_reg || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT)
        begin
            timeout_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        len_next      = len_reg;
        idle_next     = idle_reg;
        n_next        = n_reg;
        rd_ptr_next   = rd_ptr_reg;
        mem_we        = 1'b0;
        err_fire      = 1'b0;
        err_kind      = KIND_TIMEOUT;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt_fire)
                begin
                    if (evt.opcode == OP_TICK)
                    begin
                        idle_next = idle_inc;
                        if (idle_inc > timeout_reg && count_reg != '0)
                        begin
                            count_next = '0;
                            sum_next   = '0;
                            err_fire   = 1'b1;
                            err_kind   = KIND_TIMEOUT;
                        end
                    end
                    else
                    begin
                        idle_next = '0;
                        if (count_reg == '0 && evt.rx_byte != SYNC_BYTE)
                        begin
                            count_next = count_reg;
                        end
                        else if (count_reg >= CNT_W'(MAX_FRAME))
                        begin
                            count_next = '0;
                            sum_next   = '0;
                            err_fire   = 1'b1;
                            err_kind   = KIND_OVERFLOW;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_inc;
                            if (count_reg == CNT_W'(2))
                            begin
                                len_next = evt.rx_byte;
                            end
                            if (count_inc >= CNT_W'(FRAME_OVERHEAD)
                                && LEN_W'(count_inc) >= need)
                            begin
                                count_next = '0;
                                sum_next   = '0;
                                if (sum_reg == evt.rx_byte)
                                begin
                                    state_next  = ST_READ;
                                    n_next      = count_inc;
                                    rd_ptr_next = '0;
                                end
                                else
                                begin
                                    err_fire = 1'b1;
                                    err_kind = KIND_CHECKSUM;
                                end
                            end
                            else
                            begin
                                sum_next = sum_reg + evt.rx_byte;
                            end
                        end
                    end
                end
            end
            ST_READ:
            begin
                if (mem_re)
                begin
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                end
                if (rd_ptr_reg == n_reg && !pend_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pend_next      = mem_re || (pend_reg && !out_free);
        pend_idx_next  = mem_re ? rd_ptr_reg : pend_idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free)
        begin
            out_valid_next = pend_reg || err_fire;
            if (pend_reg)
            begin
                out_next.kind       = KIND_BYTE;
                out_next.data_byte  = mem_rdata;
                out_next.byte_index = pend_idx_reg[ADDR_W-1:0];
                out_next.last       = (pend_idx_reg + CNT_W'(1)) == n_reg;
            end
            else
            begin
                out_next.kind       = err_kind;
                out_next.data_byte  = '0;
                out_next.byte_index = '0;
                out_next.last       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            idle_reg      <= '0;
            rd_ptr_reg    <= '0;
            n_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            idle_reg      <= idle_next;
            rd_ptr_reg    <= rd_ptr_next;
            n_reg         <= n_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        pend_idx_reg <= pend_idx_next;
        out_reg      <= out_next;
    end

    slsfr_frame_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (evt.rx_byte),
        .re    (mem_re),
        .raddr (rd_ptr_reg[ADDR_W-1:0]),
        .rdata (mem_rdata)
    );

endmodule

// ----- src/slsfr_frame_mem.sv -----
// ============================================================================
// slsfr_frame_mem - frame byte store
// One write port and one read port; read data registered, held when idle.
// ============================================================================
module slsfr_frame_mem
    import slsfr_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [MAX_FRAME];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- verif/sync_length_sum_frame_receiver_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sync_length_sum_frame_receiver_test - self-checking bench for the deframer
// Feeds received bytes and idle ticks through the input channel and predicts
// every frame byte, checksum error, overflow and timeout. Results are compared
// field by field in arrival order, under random gaps, stalls and a long
// receiver hold-off. The timeout register is varied between phases.
// ============================================================================
module sync_length_sum_frame_receiver_test;
    import slsfr_pkg::*;

    localparam int         SETTLE_CYCLES = MAX_FRAME + 16;
    localparam int         HOLD_CYCLES   = 200;
    localparam int         QUIET_LIMIT   = 1500;
    localparam logic [2:0] TIMEOUT_ADDR  = {REG_TIMEOUT, 2'b00};

    logic        clk;
    logic        rst_n;
    logic        evt_valid;
    logic        evt_stall;
    evt_t        evt;
    logic        res_valid;
    logic        res_stall;
    res_t        res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [7:0]  frame_bytes [MAX_FRAME];
    int          held_count;
    logic [7:0]  held_sum;
    logic [15:0] idle_count;
    logic [15:0] timeout_reg;
    res_t        pending_results [$];

    bit          src_gaps;
    bit          sink_gaps;
    bit          tick_mix;
    bit          hold_request;
    int          errors;
    int          useful_items;
    int          transfers_in;
    int          frames_out;
    int          bytes_out;
    int          checksum_errors;
    int          overflows;
    int          timeouts;

    sync_length_sum_frame_receiver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic queue_result(input res_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic deframe_event(input evt_t e);
        int n;
        if (e.opcode == OP_TICK)
        begin
            if (idle_count != 16'hFFFF)
                idle_count++;
            if (held_count == 0)
                return;
            useful_items++;
            if (idle_count > timeout_reg)
            begin
                held_count = 0;
                held_sum   = 8'h00;
                queue_result({KIND_TIMEOUT, 8'h00, 6'd0, 1'b1});
            end
            return;
        end
        idle_count = 16'd0;
        if (held_count == 0 && e.rx_byte != SYNC_BYTE)
            return;
        useful_items++;
        if (held_count >= MAX_FRAME)
        begin
            held_count = 0;
            held_sum   = 8'h00;
            queue_result({KIND_OVERFLOW, 8'h00, 6'd0, 1'b1});
            return;
        end
        frame_bytes[held_count] = e.rx_byte;
        held_count++;
        if (held_count >= FRAME_OVERHEAD && held_count >= int'(frame_bytes[2]) + FRAME_OVERHEAD)
        begin
            n          = held_count;
            held_count = 0;
            if (held_sum != e.rx_byte)
                queue_result({KIND_CHECKSUM, 8'h00, 6'd0, 1'b1});
            else
                for (int i = 0; i < n; i++)
                    queue_result({KIND_BYTE, frame_bytes[i], 6'(i), 1'(i == n - 1)});
            held_sum = 8'h00;
            return;
        end
        held_sum = held_sum + e.rx_byte;
    endtask

    task automatic send_event(input evt_t e);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            evt_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        evt_valid <= 1'b1;
        evt       <= e;
        do @(posedge clk); while (evt_stall);
        transfers_in++;
        deframe_event(e);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_event({OP_BYTE, b});
    endtask

    task automatic send_tick();
        send_event({OP_TICK, 8'($urandom_range(0, 255))});
    endtask

    // stop_at < 0 sends the whole frame; oversized frames end on the overflowing byte
    task automatic send_frame(input logic [7:0] len, input bit corrupt, input int stop_at);
        logic [7:0] b;
        logic [7:0] sum;
        int         total;
        bit         fits;
        total = int'(len) + FRAME_OVERHEAD;
        fits  = total <= MAX_FRAME;
        if (!fits)
            total = MAX_FRAME + 1;
        sum = 8'h00;
        for (int i = 0; i < total; i++)
        begin
            if (i == stop_at)
                break;
            if (i == 0)
                b = SYNC_BYTE;
            else if (i == 2)
                b = len;
            else if (i == total - 1 && fits)
                b = corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum;
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b);
            sum = sum + b;
            if (tick_mix && i < total - 1 && $urandom_range(0, 7) == 0)
                send_tick();
        end
    endtask

    task automatic wait_until_drained();
        evt_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == TIMEOUT_ADDR)
            timeout_reg = value[15:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == TIMEOUT_ADDR && prdata !== {16'd0, value[15:0]})
        begin
            errors++;
            $display("%0t: readback expected %0h, got %0h", $time, {16'd0, value[15:0]},
                     prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timeout(input logic [15:0] ticks);
        wait_until_drained();
        write_reg(TIMEOUT_ADDR, {16'd0, ticks});
    endtask

    task automatic test_dropped_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h54);
        send_byte(8'hAA);
        send_tick();
        send_tick();
    endtask

    task automatic test_short_frames();
        send_byte(SYNC_BYTE);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(SYNC_BYTE);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h54);
        send_byte(SYNC_BYTE);
        send_byte(8'h12);
        send_byte(8'h01);
        send_byte(8'h34);
        send_byte(8'h00);
    endtask

    task automatic test_timeout();
        set_timeout(16'd1);
        send_byte(SYNC_BYTE);
        send_tick();
        send_tick();
    endtask

    task automatic test_frame_limits();
        set_timeout(16'hFFFF);
        send_frame(8'd60, 1'b0, -1);
        send_frame(8'd61, 1'b0, -1);
        send_frame(8'd0, 1'b0, -1);
    endtask

    task automatic test_backpressure();
        set_timeout(TIMEOUT_RESET);
        hold_request = 1'b1;
        repeat (2) send_frame(8'd8, 1'b0, -1);
    endtask

    task automatic send_random_frame();
        logic [7:0] len;
        int         shape;
        len   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(13, 60))
                                            : 8'($urandom_range(0, 12));
        shape = $urandom_range(0, 99);
        if (shape < 60 || (shape >= 80 && shape < 90 && timeout_reg > 16'd200))
            send_frame(len, 1'b0, -1);
        else if (shape < 72)
            send_frame(len, 1'b1, -1);
        else if (shape < 80)
            send_frame(8'($urandom_range(61, 255)), 1'b0, -1);
        else if (shape < 90)
        begin
            send_frame(len, 1'b0, $urandom_range(1, int'(len) + 3));
            repeat (int'(timeout_reg) + 1) send_tick();
        end
        else
            repeat ($urandom_range(1, 4)) send_event(9'($urandom_range(0, 511)));
    endtask

    task automatic run_random_phase(input logic [15:0] ticks, input int items, input bit gaps);
        int target;
        set_timeout(ticks);
        src_gaps  = gaps;
        sink_gaps = gaps;
        tick_mix  = 1'b1;
        target    = useful_items + items;
        while (useful_items < target)
            send_random_frame();
    endtask

    task automatic test_random();
        run_random_phase(16'($urandom_range(1, 6)), 12, 1'b1);
        run_random_phase(16'hFFFF, 10, 1'b1);
        run_random_phase(16'($urandom_range(7, 16)), 12, 1'b0);
    endtask

    task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got %0h", $time, res);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res.kind !== want.kind)
                    report_field("kind", 8'(want.kind), 8'(res.kind));
                if (res.data_byte !== want.data_byte)
                    report_field("data_byte", want.data_byte, res.data_byte);
                if (res.byte_index !== want.byte_index)
                    report_field("byte_index", 8'(want.byte_index), 8'(res.byte_index));
                if (res.last !== want.last)
                    report_field("last", 8'(want.last), 8'(res.last));
            end
            case (res.kind)
                KIND_BYTE:
                begin
                    bytes_out++;
                    if (res.last)
                        frames_out++;
                end
                KIND_CHECKSUM: checksum_errors++;
                KIND_OVERFLOW: overflows++;
                default:       timeouts++;
            endcase
        end
    end

    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (sink_gaps && $urandom_range(0, 3) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((evt_valid && !evt_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, pending_results.size());
        $display("sync_length_sum_frame_receiver: mismatch");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        evt_valid    = 1'b0;
        evt          = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        held_count   = 0;
        held_sum     = 8'h00;
        idle_count   = 16'd0;
        timeout_reg  = TIMEOUT_RESET;
        src_gaps     = 1'b1;
        sink_gaps    = 1'b1;
        tick_mix     = 1'b0;
        hold_request = 1'b0;
        errors       = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_dropped_bytes();
        test_short_frames();
        test_timeout();
        test_frame_limits();
        test_backpressure();
        test_random();
        wait_until_drained();

        $display("Run: %0d input transfers, %0d frames (%0d bytes) delivered,", transfers_in,
                 frames_out, bytes_out);
        $display("     %0d checksum errors, %0d overflows, %0d timeouts, %0d field errors",
                 checksum_errors, overflows, timeouts, errors);
        if (errors == 0)
            $display("sync_length_sum_frame_receiver: match");
        else
            $display("sync_length_sum_frame_receiver: mismatch");
        $finish;
    end

endmodule
